>>> hw/rtl/jsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types and constants of the json string unescaper: status codes,
// the job record passed from the front end to the output side, queue depth
// ----------------------------------------------------------------------------
package jsu_pkg;

  // status codes carried on every result item
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_TRAIL_BSLASH = 3'd1;
  localparam logic [2:0] ST_SHORT_U      = 3'd2;
  localparam logic [2:0] ST_BAD_HEX      = 3'd3;
  localparam logic [2:0] ST_MISSING_LOW  = 3'd4;
  localparam logic [2:0] ST_BAD_LOW      = 3'd5;
  localparam logic [2:0] ST_LONE_LOW     = 3'd6;
  localparam logic [2:0] ST_ILLEGAL_ESC  = 3'd7;

  // depth of the job queue between front end and output side
  localparam int unsigned QDEPTH = 4;

  // one decoded input item: up to four output bytes, sent lowest index first
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      n_m1;    // number of bytes minus one
    logic            last;    // string ends with the final byte of this job
    logic [2:0]      status;
  } job_t;

endpackage : jsu_pkg
`default_nettype wire

>>> hw/rtl/json_string_unescape_utf8_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// json string body unescaper with utf-8 output
// ----------------------------------------------------------------------------
// Takes one string body byte per cycle (push/full) and hands out decoded
// bytes one per cycle (empty/pop), each with a last mark and a status code.
// A byte is decoded in the cycle it is accepted and yields zero or one job
// of one to four output bytes in a four-entry job queue; the output side
// then hands the bytes of the head job out in order (at most four, for a
// surrogate pair). Input and output stall independently; full rises only
// when four jobs wait behind the output register. An error gives a single
// zero byte with the status code and the last mark, and the rest of that
// string is swallowed up to its last byte.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        in_last_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o,
  output logic [2:0]       status_o
);

  jsu_pkg::job_t job_w;
  jsu_pkg::job_t head_w;
  logic          job_push;
  logic          q_full;
  logic          q_empty;
  logic          q_rd;
  logic          accept;

  assign accept = push && !q_full;
  assign full   = q_full;

  // decoder
  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .job_o      (job_w),
    .job_push_o (job_push)
  );

  // job queue
  jsu_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (job_push),
    .wr_data_i (job_w),
    .full_o    (q_full),
    .rd_en_i   (q_rd),
    .rd_data_o (head_w),
    .empty_o   (q_empty)
  );

  // output side
  jsu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_job_i    (head_w),
    .q_rd_o     (q_rd),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o),
    .status_o   (status_o)
  );

endmodule : json_string_unescape_utf8_top
`default_nettype wire

>>> hw/rtl/jsu_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_front
// escape decoder: one body byte a cycle while accepted, tracks the escape
// state and turns each byte into zero or one job of up to four utf-8 bytes
// ----------------------------------------------------------------------------
module jsu_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire logic [7:0]   in_byte_i,
  input  wire logic         in_last_i,
  output jsu_pkg::job_t     job_o,
  output logic              job_push_o
);

  // decoder phases
  localparam logic [2:0] PH_NORMAL = 3'd0;
  localparam logic [2:0] PH_ESC    = 3'd1;
  localparam logic [2:0] PH_HI     = 3'd2;
  localparam logic [2:0] PH_HI_BAD = 3'd3;
  localparam logic [2:0] PH_BS2    = 3'd4;
  localparam logic [2:0] PH_U2     = 3'd5;
  localparam logic [2:0] PH_LO     = 3'd6;
  localparam logic [2:0] PH_LO_BAD = 3'd7;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] hex_q, hex_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [9:0]  hi_q, hi_d;
  logic        drop_q, drop_d;

  jsu_pkg::job_t job;
  logic          job_valid;

  logic [3:0]  digit;
  logic        digit_ok;
  logic        high;
  logic        bad;
  logic [15:0] hex_next;
  logic [20:0] pair_cp;

  // encode a code point as a utf-8 job
  function automatic jsu_pkg::job_t utf8_job(input logic [20:0] cp, input logic last);
    jsu_pkg::job_t j;
    j        = '0;
    j.last   = last;
    j.status = jsu_pkg::ST_OK;
    if (cp < 21'h80) begin
      j.bytes[0] = cp[7:0];
      j.n_m1     = 2'd0;
    end else if (cp < 21'h800) begin
      j.bytes[0] = {3'b110, cp[10:6]};
      j.bytes[1] = {2'b10, cp[5:0]};
      j.n_m1     = 2'd1;
    end else if (cp < 21'h10000) begin
      j.bytes[0] = {4'b1110, cp[15:12]};
      j.bytes[1] = {2'b10, cp[11:6]};
      j.bytes[2] = {2'b10, cp[5:0]};
      j.n_m1     = 2'd2;
    end else begin
      j.bytes[0] = {5'b11110, cp[20:18]};
      j.bytes[1] = {2'b10, cp[17:12]};
      j.bytes[2] = {2'b10, cp[11:6]};
      j.bytes[3] = {2'b10, cp[5:0]};
      j.n_m1     = 2'd3;
    end
    return j;
  endfunction

  // single-byte job, used for plain bytes, short escapes and errors
  function automatic jsu_pkg::job_t byte_job(input logic [7:0] b, input logic last,
                                             input logic [2:0] st);
    jsu_pkg::job_t j;
    j          = '0;
    j.bytes[0] = b;
    j.n_m1     = 2'd0;
    j.last     = last;
    j.status   = st;
    return j;
  endfunction

  // hex digit value, invalid digits count as all ones
  always_comb begin
    digit_ok = 1'b1;
    digit    = 4'hf;
    if (in_byte_i inside {[8'h30:8'h39]}) begin
      digit = in_byte_i[3:0];
    end else if (in_byte_i inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      digit = in_byte_i[3:0] + 4'd9;
    end else begin
      digit_ok = 1'b0;
    end
  end

  assign high     = (phase_q == PH_HI) || (phase_q == PH_HI_BAD);
  assign bad      = (phase_q == PH_HI_BAD) || (phase_q == PH_LO_BAD) || !digit_ok;
  assign hex_next = {hex_q[11:0], digit};
  assign pair_cp  = 21'h10000 + {1'b0, hi_q, hex_next[9:0]};

  // next state and job for the byte on the inputs
  always_comb begin
    phase_d   = phase_q;
    hex_d     = hex_q;
    cnt_d     = cnt_q;
    hi_d      = hi_q;
    drop_d    = drop_q;
    job       = byte_job(in_byte_i, in_last_i, jsu_pkg::ST_OK);
    job_valid = 1'b0;

    if (drop_q) begin
      if (in_last_i) begin
        drop_d  = 1'b0;
        phase_d = PH_NORMAL;
      end
    end else begin
      case (phase_q)
        PH_ESC: begin
          phase_d   = PH_NORMAL;
          job_valid = 1'b1;
          case (in_byte_i)
            8'h22, 8'h5c, 8'h2f: job = byte_job(in_byte_i, in_last_i, jsu_pkg::ST_OK);
            8'h62: job = byte_job(8'h08, in_last_i, jsu_pkg::ST_OK);
            8'h66: job = byte_job(8'h0c, in_last_i, jsu_pkg::ST_OK);
            8'h6e: job = byte_job(8'h0a, in_last_i, jsu_pkg::ST_OK);
            8'h72: job = byte_job(8'h0d, in_last_i, jsu_pkg::ST_OK);
            8'h74: job = byte_job(8'h09, in_last_i, jsu_pkg::ST_OK);
            8'h75: begin
              if (in_last_i) begin
                job = byte_job(8'h00, 1'b1, jsu_pkg::ST_SHORT_U);
              end else begin
                job_valid = 1'b0;
                phase_d   = PH_HI;
                hex_d     = '0;
                cnt_d     = '0;
              end
            end
            default: job = byte_job(8'h00, 1'b1, jsu_pkg::ST_ILLEGAL_ESC);
          endcase
          if (job.status != jsu_pkg::ST_OK) begin
            drop_d = !in_last_i;
          end
        end

        PH_HI, PH_HI_BAD, PH_LO, PH_LO_BAD: begin
          hex_d = hex_next;
          if (cnt_q == 2'd3) begin
            // fourth digit: judge the whole group
            cnt_d     = '0;
            phase_d   = PH_NORMAL;
            job_valid = 1'b1;
            if (bad) begin
              job = byte_job(8'h00, 1'b1, jsu_pkg::ST_BAD_HEX);
            end else if (high) begin
              if (hex_next inside {[16'hd800:16'hdbff]}) begin
                if (in_last_i) begin
                  job = byte_job(8'h00, 1'b1, jsu_pkg::ST_MISSING_LOW);
                end else begin
                  job_valid = 1'b0;
                  hi_d      = hex_next[9:0];
                  phase_d   = PH_BS2;
                end
              end else if (hex_next inside {[16'hdc00:16'hdfff]}) begin
                job = byte_job(8'h00, 1'b1, jsu_pkg::ST_LONE_LOW);
              end else begin
                job = utf8_job({5'd0, hex_next}, in_last_i);
              end
            end else begin
              if (hex_next inside {[16'hdc00:16'hdfff]}) begin
                job = utf8_job(pair_cp, in_last_i);
              end else begin
                job = byte_job(8'h00, 1'b1, jsu_pkg::ST_BAD_LOW);
              end
            end
          end else if (in_last_i) begin
            // string ends inside the group
            phase_d   = PH_NORMAL;
            job_valid = 1'b1;
            job       = byte_job(8'h00, 1'b1,
                                 high ? jsu_pkg::ST_SHORT_U : jsu_pkg::ST_MISSING_LOW);
          end else begin
            cnt_d = cnt_q + 2'd1;
            if (high) begin
              phase_d = bad ? PH_HI_BAD : PH_HI;
            end else begin
              phase_d = bad ? PH_LO_BAD : PH_LO;
            end
          end
          if (job_valid && job.status != jsu_pkg::ST_OK) begin
            drop_d = !in_last_i;
          end
        end

        PH_BS2, PH_U2: begin
          // expect the backslash and u of the low surrogate escape
          if (in_last_i || in_byte_i != ((phase_q == PH_BS2) ? 8'h5c : 8'h75)) begin
            phase_d   = PH_NORMAL;
            job_valid = 1'b1;
            job       = byte_job(8'h00, 1'b1, jsu_pkg::ST_MISSING_LOW);
            drop_d    = !in_last_i;
          end else if (phase_q == PH_BS2) begin
            phase_d = PH_U2;
          end else begin
            phase_d = PH_LO;
            hex_d   = '0;
            cnt_d   = '0;
          end
        end

        default: begin
          phase_d = PH_NORMAL;
          if (in_byte_i != 8'h5c) begin
            job_valid = 1'b1;
          end else if (in_last_i) begin
            job_valid = 1'b1;
            job       = byte_job(8'h00, 1'b1, jsu_pkg::ST_TRAIL_BSLASH);
          end else begin
            phase_d = PH_ESC;
          end
        end
      endcase
    end
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NORMAL;
      hex_q   <= '0;
      cnt_q   <= '0;
      hi_q    <= '0;
      drop_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      hex_q   <= hex_d;
      cnt_q   <= cnt_d;
      hi_q    <= hi_d;
      drop_q  <= drop_d;
    end
  end

  assign job_o      = job;
  assign job_push_o = accept_i && job_valid;

  // an error job is a single closing byte of value zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_push_o && job_o.status != jsu_pkg::ST_OK) |->
      (job_o.last && job_o.n_m1 == 2'd0 && job_o.bytes[0] == 8'h00))
    else $error("error job is not a single closing zero byte");

  // while dropping, no byte yields a job
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> !job_push_o)
    else $error("job produced while dropping");

  // an error on a byte that is not the last starts dropping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_push_o && job_o.status != jsu_pkg::ST_OK && !in_last_i) |=> drop_q)
    else $error("no dropping after error");

endmodule : jsu_front
`default_nettype wire

>>> hw/rtl/jsu_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_queue
// small job queue between the decoder and the output side
// ----------------------------------------------------------------------------
module jsu_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_en_i,
  input  wire jsu_pkg::job_t wr_data_i,
  output logic               full_o,
  input  wire logic          rd_en_i,
  output jsu_pkg::job_t      rd_data_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (jsu_pkg::QDEPTH > 1) ? $clog2(jsu_pkg::QDEPTH) : 1;
  localparam int unsigned CntW = $clog2(jsu_pkg::QDEPTH + 1);
  localparam logic [CntW-1:0] Depth = CntW'(jsu_pkg::QDEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(jsu_pkg::QDEPTH - 1);

  jsu_pkg::job_t mem_q [jsu_pkg::QDEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o    = (cnt_q == Depth);
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (rd_en_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (wr_en_i && !rd_en_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (rd_en_i && !wr_en_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(wr_en_i && full_o))
    else $error("write into full job queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(rd_en_i && empty_o))
    else $error("read from empty job queue");

endmodule : jsu_queue
`default_nettype wire

>>> hw/rtl/jsu_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_back
// output side: walks the bytes of the head job into the result register,
// one byte a cycle unless pop stalls, retiring the job after its final byte
// ----------------------------------------------------------------------------
module jsu_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_empty_i,
  input  wire jsu_pkg::job_t q_job_i,
  output logic               q_rd_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o,
  output logic [2:0]         status_o
);

  logic [1:0] idx_q, idx_d;
  logic       ov_q, ov_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic [2:0] status_q;
  logic       load;
  logic       at_end;
  logic       take;

  // load the next byte when the result register is free or being taken
  assign take   = pop_i && ov_q;
  assign load   = !q_empty_i && (!ov_q || take);
  assign at_end = (idx_q == q_job_i.n_m1);
  assign q_rd_o = load && at_end;

  always_comb begin
    idx_d = idx_q;
    ov_d  = ov_q;
    if (load) begin
      idx_d = at_end ? 2'd0 : idx_q + 2'd1;
      ov_d  = 1'b1;
    end else if (take) begin
      ov_d  = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      ov_q  <= ov_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= q_job_i.bytes[idx_q];
      last_q   <= q_job_i.last && at_end;
      status_q <= q_job_i.status;
    end
  end

  assign empty_o    = !ov_q;
  assign out_byte_o = byte_q;
  assign out_last_o = last_q;
  assign status_o   = status_q;

  // an error result always closes the string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && status_q != jsu_pkg::ST_OK) |-> last_q)
    else $error("error result without last mark");

endmodule : jsu_back
`default_nettype wire

>>> test/json_string_unescape_utf8_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_checker
// watches both ports of the unescaper, works out the decoded bytes of every
// accepted input item and compares each popped result, field by field, with
// the oldest decoded byte still waiting
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire logic       full_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  input  wire logic       empty_i,
  input  wire logic       pop_i,
  input  wire logic [7:0] out_byte_i,
  input  wire logic       out_last_i,
  input  wire logic [2:0] status_i,
  output int              mismatch_count_o,
  output int              pending_o,
  output int              results_o
);

  // where the decoder stands inside an escape
  typedef enum logic [3:0] {
    DEC_PLAIN,
    DEC_ESC,
    DEC_HI,
    DEC_HI_BAD,
    DEC_BS2,
    DEC_U2,
    DEC_LO,
    DEC_LO_BAD
  } dec_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [2:0] status;
  } decoded_t;

  decoded_t   decoded_q[$];
  dec_phase_e phase;
  logic [15:0] hex_acc;
  logic [1:0]  digit_cnt;
  logic [9:0]  hi_sur;
  logic        dropping;

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
    results_o        = 0;
  end

  task automatic put_decoded(input logic [7:0] b, input logic l, input logic [2:0] st);
    decoded_t d;
    d.data   = b;
    d.last   = l;
    d.status = st;
    decoded_q.insert(decoded_q.size(), d);
  endtask

  // an error closes the string; the rest of it is swallowed unless it ended here
  task automatic raise_error(input logic l, input logic [2:0] st);
    phase    = DEC_PLAIN;
    dropping = !l;
    put_decoded(8'h00, 1'b1, st);
  endtask

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 'h30;
    if (c >= "A" && c <= "F") return int'(c) - 'h37;
    if (c >= "a" && c <= "f") return int'(c) - 'h57;
    return -1;
  endfunction

  // code point to one to four utf-8 bytes, last mark on the final one
  task automatic put_utf8(input logic [20:0] cp, input logic l);
    phase = DEC_PLAIN;
    if (cp < 21'h80) begin
      put_decoded(cp[7:0], l, jsu_pkg::ST_OK);
    end else if (cp < 21'h800) begin
      put_decoded({3'b110, cp[10:6]}, 1'b0, jsu_pkg::ST_OK);
      put_decoded({2'b10, cp[5:0]}, l, jsu_pkg::ST_OK);
    end else if (cp < 21'h10000) begin
      put_decoded({4'b1110, cp[15:12]}, 1'b0, jsu_pkg::ST_OK);
      put_decoded({2'b10, cp[11:6]}, 1'b0, jsu_pkg::ST_OK);
      put_decoded({2'b10, cp[5:0]}, l, jsu_pkg::ST_OK);
    end else begin
      put_decoded({5'b11110, cp[20:18]}, 1'b0, jsu_pkg::ST_OK);
      put_decoded({2'b10, cp[17:12]}, 1'b0, jsu_pkg::ST_OK);
      put_decoded({2'b10, cp[11:6]}, 1'b0, jsu_pkg::ST_OK);
      put_decoded({2'b10, cp[5:0]}, l, jsu_pkg::ST_OK);
    end
  endtask

  task automatic simple_escape(input logic [7:0] b, input logic l);
    phase = DEC_PLAIN;
    put_decoded(b, l, jsu_pkg::ST_OK);
  endtask

  // one accepted input byte through the decoder
  task automatic unescape_byte(input logic [7:0] c, input logic l);
    int          d;
    logic        high;
    logic        bad;
    logic [15:0] v;
    if (dropping) begin
      if (l) begin
        dropping = 1'b0;
        phase    = DEC_PLAIN;
      end
      return;
    end
    case (phase)
      DEC_ESC: begin
        case (c)
          "\"", "\\", "/": simple_escape(c, l);
          "b": simple_escape(8'h08, l);
          "f": simple_escape(8'h0C, l);
          "n": simple_escape(8'h0A, l);
          "r": simple_escape(8'h0D, l);
          "t": simple_escape(8'h09, l);
          "u": begin
            if (l) begin
              raise_error(l, jsu_pkg::ST_SHORT_U);
            end else begin
              phase     = DEC_HI;
              hex_acc   = 16'h0000;
              digit_cnt = 2'd0;
            end
          end
          default: raise_error(l, jsu_pkg::ST_ILLEGAL_ESC);
        endcase
      end
      DEC_HI, DEC_HI_BAD, DEC_LO, DEC_LO_BAD: begin
        high    = (phase == DEC_HI) || (phase == DEC_HI_BAD);
        d       = hex_nibble(c);
        bad     = (phase == DEC_HI_BAD) || (phase == DEC_LO_BAD) || (d < 0);
        hex_acc = {hex_acc[11:0], d[3:0]};
        if (digit_cnt == 2'd3) begin
          v         = hex_acc;
          digit_cnt = 2'd0;
          if (bad) begin
            raise_error(l, jsu_pkg::ST_BAD_HEX);
          end else if (high) begin
            if (v >= 16'hD800 && v <= 16'hDBFF) begin
              if (l) begin
                raise_error(l, jsu_pkg::ST_MISSING_LOW);
              end else begin
                hi_sur = v[9:0];
                phase  = DEC_BS2;
              end
            end else if (v >= 16'hDC00 && v <= 16'hDFFF) begin
              raise_error(l, jsu_pkg::ST_LONE_LOW);
            end else begin
              put_utf8({5'd0, v}, l);
            end
          end else if (v < 16'hDC00 || v > 16'hDFFF) begin
            raise_error(l, jsu_pkg::ST_BAD_LOW);
          end else begin
            put_utf8({1'b0, hi_sur, v[9:0]} + 21'h10000, l);
          end
        end else if (l) begin
          raise_error(l, high ? jsu_pkg::ST_SHORT_U : jsu_pkg::ST_MISSING_LOW);
        end else begin
          digit_cnt = digit_cnt + 2'd1;
          if (high) phase = bad ? DEC_HI_BAD : DEC_HI;
          else      phase = bad ? DEC_LO_BAD : DEC_LO;
        end
      end
      // after a high surrogate only a second \u may follow
      DEC_BS2: begin
        if (c != "\\" || l) raise_error(l, jsu_pkg::ST_MISSING_LOW);
        else phase = DEC_U2;
      end
      DEC_U2: begin
        if (c != "u" || l) begin
          raise_error(l, jsu_pkg::ST_MISSING_LOW);
        end else begin
          phase     = DEC_LO;
          hex_acc   = 16'h0000;
          digit_cnt = 2'd0;
        end
      end
      default: begin
        phase = DEC_PLAIN;
        if (c != "\\") put_decoded(c, l, jsu_pkg::ST_OK);
        else if (l) raise_error(l, jsu_pkg::ST_TRAIL_BSLASH);
        else phase = DEC_ESC;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d: %s is 0x%0h, wanted 0x%0h", results_o, what, got, want);
    mismatch_count_o++;
  endtask

  task automatic check_result();
    decoded_t w;
    if (decoded_q.size() == 0) begin
      report_mismatch("unexpected result, byte", int'(out_byte_i), 0);
    end else begin
      w = decoded_q.pop_front();
      if (out_byte_i !== w.data)
        report_mismatch("out_byte", int'(out_byte_i), int'(w.data));
      if (out_last_i !== w.last)
        report_mismatch("out_last", int'(out_last_i), int'(w.last));
      if (status_i !== w.status)
        report_mismatch("status", int'(status_i), int'(w.status));
    end
    results_o++;
  endtask

  // predict on every accepted input item, compare on every accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase     = DEC_PLAIN;
      hex_acc   = 16'h0000;
      digit_cnt = 2'd0;
      hi_sur    = 10'd0;
      dropping  = 1'b0;
      decoded_q.delete();
      pending_o <= 0;
    end else begin
      if (push_i && !full_i) unescape_byte(in_byte_i, in_last_i);
      if (pop_i && !empty_i) check_result();
      pending_o <= decoded_q.size();
    end
  end

endmodule

>>> test/json_string_unescape_utf8_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top_tb
// feeds string bodies to the unescaper: a few hand-picked strings, then random
// strings of well-formed escapes mixed with broken ones, with bursty input,
// patterned output stalls and one long stall; the checker does the comparing
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top_tb;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_START = 150;
  localparam int HOLD_LEN   = 400;
  localparam int HALF_ITEMS = 130;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stim_t;

  logic       clk_i   = 1'b0;
  logic       rst_ni  = 1'b0;
  logic       push    = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       pop     = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       out_last;
  logic [2:0] status;

  int n_mismatch;
  int n_pending;
  int n_results;
  int n_sent      = 0;
  int n_strings   = 0;
  int idle_cycles = 0;

  stim_t      stim_q[$];
  logic [7:0] str_q[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  json_string_unescape_utf8_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_byte_i  (in_byte),
    .in_last_i  (in_last),
    .empty      (empty),
    .pop        (pop),
    .out_byte_o (out_byte),
    .out_last_o (out_last),
    .status_o   (status)
  );

  json_string_unescape_utf8_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_i           (full),
    .in_byte_i        (in_byte),
    .in_last_i        (in_last),
    .empty_i          (empty),
    .pop_i            (pop),
    .out_byte_i       (out_byte),
    .out_last_i       (out_last),
    .status_i         (status),
    .mismatch_count_o (n_mismatch),
    .pending_o        (n_pending),
    .results_o        (n_results)
  );

  // ---------------------------------------------------------------- strings

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic bit is_escape_char(input logic [7:0] c);
    return c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
           c == "n" || c == "r" || c == "t" || c == "u";
  endfunction

  // hex digit in random case; 'a' - 10 = 0x57, 'A' - 10 = 0x37
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return ($urandom_range(0, 1) ? 8'h57 : 8'h37) + {4'h0, n};
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_hex(c));
    return c;
  endfunction

  // append one byte to the string being built
  task automatic add_byte(input logic [7:0] c);
    str_q.insert(str_q.size(), c);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // \u and four digits; a digit at bad_pos is swapped for a non-hex byte
  task automatic add_u_group(input logic [15:0] v, input int bad_pos);
    add_text("\\u");
    for (int i = 3; i >= 0; i--) begin
      if (3 - i == bad_pos) add_byte(non_hex_byte());
      else add_byte(hex_char(v[4*i +: 4]));
    end
  endtask

  task automatic end_string();
    stim_t s;
    for (int i = 0; i < str_q.size(); i++) begin
      s.data = str_q[i];
      s.last = (i == str_q.size() - 1);
      stim_q.insert(stim_q.size(), s);
    end
    str_q.delete();
    n_strings++;
  endtask

  function automatic logic [15:0] rand_high();
    return 16'hD800 + 16'($urandom_range(0, 16'h3FF));
  endfunction

  function automatic logic [15:0] rand_low();
    return 16'hDC00 + 16'($urandom_range(0, 16'h3FF));
  endfunction

  // one piece of a string body; cut is set when the string must end here
  task automatic add_segment(output bit cut);
    string      esc_set;
    int         roll;
    int         n_cut;
    logic [7:0] c;
    logic [15:0] v;
    esc_set = "\"\\/bfnrt";
    cut     = 1'b0;
    roll    = $urandom_range(0, 99);
    if (roll < 35) begin
      // plain byte, never a backslash
      c = 8'($urandom_range(0, 255));
      if (c == "\\") c = c ^ 8'h01;
      add_byte(c);
    end else if (roll < 50) begin
      add_byte("\\");
      add_byte(esc_set[$urandom_range(0, 7)]);
    end else if (roll < 70) begin
      case ($urandom_range(0, 2))
        0:       v = 16'($urandom_range(0, 16'h7F));
        1:       v = 16'($urandom_range(16'h80, 16'h7FF));
        default: v = 16'($urandom_range(16'h800, 16'hFFFF));
      endcase
      add_u_group(v, -1);
    end else if (roll < 82) begin
      add_u_group(rand_high(), -1);
      add_u_group(rand_low(), -1);
    end else begin
      // broken sequences
      case ($urandom_range(0, 5))
        0: begin
          add_byte("\\");
          do c = 8'($urandom_range(0, 255)); while (is_escape_char(c));
          add_byte(c);
        end
        1: begin
          if ($urandom_range(0, 1)) begin
            add_u_group(16'($urandom_range(0, 16'hFFFF)), int'($urandom_range(0, 3)));
          end else begin
            add_u_group(rand_high(), -1);
            add_u_group(rand_low(), int'($urandom_range(0, 3)));
          end
        end
        2: begin
          add_u_group(rand_high(), -1);
          do v = 16'($urandom_range(0, 16'hFFFF)); while (v >= 16'hDC00 && v <= 16'hDFFF);
          add_u_group(v, -1);
        end
        3: begin
          add_u_group(rand_high(), -1);
          if ($urandom_range(0, 1)) begin
            c = 8'($urandom_range(0, 255));
            if (c == "\\") c = "x";
            add_byte(c);
          end else begin
            add_byte("\\");
            do c = 8'($urandom_range(0, 255)); while (c == "u");
            add_byte(c);
          end
        end
        4: add_u_group(rand_low(), -1);
        default: begin
          // string ends somewhere inside an escape
          if ($urandom_range(0, 1)) begin
            add_u_group(rand_high(), -1);
            add_u_group(rand_low(), -1);
            n_cut = $urandom_range(1, 11);
          end else begin
            add_u_group(16'($urandom_range(0, 16'hFFFF)), -1);
            n_cut = $urandom_range(1, 5);
          end
          repeat (n_cut) void'(str_q.pop_back());
          cut = 1'b1;
        end
      endcase
    end
  endtask

  task automatic add_string();
    int nseg;
    bit cut;
    nseg = $urandom_range(1, 6);
    cut  = 1'b0;
    for (int i = 0; i < nseg && !cut; i++) add_segment(cut);
    end_string();
  endtask

  // ---------------------------------------------------------------- driving

  task automatic send_item(input logic [7:0] b, input logic l);
    push    <= 1'b1;
    in_byte <= b;
    in_last <= l;
    do @(posedge clk_i); while (full);
    n_sent++;
  endtask

  // bursts of random length, random gaps, sometimes none
  task automatic drive_items();
    int    burst;
    int    gap;
    stim_t s;
    while (stim_q.size() > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && stim_q.size() > 0) begin
        s = stim_q.pop_front();
        send_item(s.data, s.last);
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    push <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    wait (n_pending == 0);
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- main flow
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed strings
    add_byte(8'h00);
    end_string();
    add_byte(8'hFF);
    end_string();
    add_text("\\");         // trailing backslash
    end_string();
    add_text("\\u");        // \u cut short on the last byte
    end_string();
    add_text("\\q");        // illegal escape on the last byte
    end_string();
    add_text("\\u0000");    // code point zero passes as a plain zero byte
    end_string();
    add_text("\\uD83D\\ude00");
    end_string();
    add_text("\\uDBFF\\uDFFF");
    end_string();
    drive_items();
    wait_drained();

    // random strings in two halves with a full drain between
    repeat (2) begin
      while (stim_q.size() < HALF_ITEMS) add_string();
      drive_items();
      wait_drained();
    end
    repeat (20) @(posedge clk_i);

    $display("covered %0d input bytes in %0d strings, %0d results popped",
             n_sent, n_strings, n_results);
    $display("escapes, surrogate pairs and every error kind, with bursty input and stalls");
    if (n_mismatch == 0) begin
      $display("json_string_unescape_utf8_top regression: pass");
    end else begin
      $display("json_string_unescape_utf8_top regression: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver
  // stall patterns that change at random, and one long hold-off
  initial begin : rx_side
    int cyc;
    int span;
    int mode;
    cyc  = 0;
    span = 0;
    mode = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
        pop <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(20, 80);
        end
        span--;
        case (mode)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          2:       pop <= ($urandom_range(0, 9) == 0);
          default: pop <= cyc[0];
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no item moved for %0d cycles", IDLE_LIMIT);
        $display("json_string_unescape_utf8_top regression: fail");
        $finish;
      end
    end
  end

endmodule

>>> filelist.f
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_front.sv
hw/rtl/jsu_queue.sv
hw/rtl/jsu_back.sv
hw/rtl/json_string_unescape_utf8_top.sv
test/json_string_unescape_utf8_checker.sv
test/json_string_unescape_utf8_top_tb.sv
